>>> design/sfcp_pkg.sv
// Shared types, opcodes, action codes and limits for the serial command frame parser.
`timescale 1ns / 1ps

package sfcp_pkg;

  // Received opcodes
  localparam logic [7:0] OP_VOLUME      = 8'h00;
  localparam logic [7:0] OP_FOLDER      = 8'h01;
  localparam logic [7:0] OP_LOG_DUMP    = 8'h02;
  localparam logic [7:0] OP_DUTY        = 8'h04;
  localparam logic [7:0] OP_SCHEDULE    = 8'h05;
  localparam logic [7:0] OP_STATUS      = 8'h06;
  localparam logic [7:0] OP_CLEAR_SCHED = 8'h07;
  localparam logic [7:0] OP_CLEAR_LOGS  = 8'h08;
  localparam logic [7:0] OP_SET_TIME    = 8'h0F;
  localparam logic [7:0] OP_TIME_QUERY  = 8'h10;
  localparam logic [7:0] END_BYTE       = 8'h0D;

  // Action codes on the result word
  localparam logic [3:0] ACT_VOLUME      = 4'd0;
  localparam logic [3:0] ACT_DUTY        = 4'd1;
  localparam logic [3:0] ACT_PLAY        = 4'd2;
  localparam logic [3:0] ACT_LOG_DUMP    = 4'd3;
  localparam logic [3:0] ACT_STATUS      = 4'd4;
  localparam logic [3:0] ACT_CLEAR_SCHED = 4'd5;
  localparam logic [3:0] ACT_CLEAR_LOGS  = 4'd6;
  localparam logic [3:0] ACT_TIME_QUERY  = 4'd7;
  localparam logic [3:0] ACT_SCHED_BEGIN = 4'd8;
  localparam logic [3:0] ACT_SCHED_APPEND = 4'd9;
  localparam logic [3:0] ACT_STOP_REPLY  = 4'd10;
  localparam logic [3:0] ACT_CLOCK_WRITE = 4'd11;
  localparam logic [3:0] ACT_TIME_ERROR  = 4'd12;

  // Record byte positions
  localparam int REC_BYTES = 7;
  localparam logic [2:0] REC_LAST_IDX = 3'd6;
  localparam int REC_FOLDER_IDX = 5;
  localparam int REC_TRACK_IDX  = 6;

  // Clock field of the set-time run
  localparam logic [1:0] FIELD_MONTH = 2'd3;

  localparam logic [7:0] SCHEDULE_LIMIT_RESET = 8'd180;
  localparam logic [7:0] COUNT_MAX = 8'd255;

  // Command queue between the front and back parts
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef logic [REC_BYTES-1:0][7:0] sfcp_rec_t;

  // One classified command: a result word, optionally followed by a stop reply
  typedef struct packed {
    logic [3:0] action;
    logic [7:0] value;
    sfcp_rec_t  rec;
    logic [1:0] field;
    logic       with_stop;
  } sfcp_cmd_t;

  // Largest accepted value of each set-time field
  function automatic logic [7:0] time_max(input logic [1:0] f);
    logic [7:0] m;
    case (f)
      2'd0:    m = 8'd59;
      2'd1:    m = 8'd23;
      2'd2:    m = 8'd31;
      default: m = 8'd12;
    endcase
    return m;
  endfunction

endpackage

>>> design/sfcp_front.sv
// Front part: accepts received bytes, tracks the frame state and classifies each byte.
`timescale 1ns / 1ps

module sfcp_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [7:0]       rx_byte,
  input  logic [7:0]       schedule_limit,
  output logic             push,
  output sfcp_pkg::sfcp_cmd_t cmd
);
  import sfcp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_VOLUME,
    S_FOLDER,
    S_TRACK,
    S_DUTY,
    S_REC_START,
    S_REC_BODY,
    S_DRAIN,
    S_TIME
  } state_t;

  state_t     state, state_next;
  logic [2:0] rec_idx, rec_idx_next;
  logic [1:0] time_idx, time_idx_next;
  logic [7:0] held_folder, held_folder_next;
  sfcp_rec_t  rec, rec_next;
  logic [7:0] record_count, record_count_next;
  logic       accept;

  assign accept = in_valid && !in_stall;

  // Decode the byte against the current frame state
  always_comb begin
    state_next        = state;
    rec_idx_next      = rec_idx;
    time_idx_next     = time_idx;
    held_folder_next  = held_folder;
    rec_next          = rec;
    record_count_next = record_count;
    push              = 1'b0;
    cmd               = '0;
    if (accept) begin
      case (state)
        S_VOLUME, S_DUTY: begin
          push       = 1'b1;
          cmd.action = (state == S_VOLUME) ? ACT_VOLUME : ACT_DUTY;
          cmd.value  = rx_byte;
          state_next = S_IDLE;
        end
        S_FOLDER: begin
          held_folder_next = rx_byte;
          state_next       = S_TRACK;
        end
        S_TRACK: begin
          push                      = 1'b1;
          cmd.action                = ACT_PLAY;
          cmd.rec[REC_FOLDER_IDX]   = held_folder;
          cmd.rec[REC_TRACK_IDX]    = rx_byte;
          state_next                = S_IDLE;
        end
        S_REC_START: begin
          cmd.action = ACT_SCHED_APPEND;
          cmd.rec    = rec;
          if (rx_byte == END_BYTE) begin
            push       = 1'b1;
            state_next = S_IDLE;
          end else if (record_count > schedule_limit) begin
            push          = 1'b1;
            cmd.with_stop = 1'b1;
            state_next    = S_DRAIN;
          end else begin
            push         = (record_count != 8'd0);
            rec_next[0]  = rx_byte;
            rec_idx_next = 3'd1;
            state_next   = S_REC_BODY;
          end
        end
        S_REC_BODY: begin
          rec_next[rec_idx] = rx_byte;
          if (rec_idx == REC_LAST_IDX) begin
            if (record_count != COUNT_MAX) begin
              record_count_next = record_count + 8'd1;
            end
            state_next = S_REC_START;
          end else begin
            rec_idx_next = rec_idx + 3'd1;
          end
        end
        S_DRAIN: begin
          if (rx_byte == END_BYTE) begin
            state_next = S_IDLE;
          end
        end
        S_TIME: begin
          push = 1'b1;
          if (rx_byte <= time_max(time_idx)) begin
            cmd.action = ACT_CLOCK_WRITE;
            cmd.value  = rx_byte;
            cmd.field  = time_idx;
            if (time_idx == FIELD_MONTH) begin
              state_next = S_IDLE;
            end else begin
              time_idx_next = time_idx + 2'd1;
            end
          end else begin
            cmd.action = ACT_TIME_ERROR;
            cmd.value  = {6'd0, time_idx};
            state_next = S_IDLE;
          end
        end
        default: begin
          // Idle: decode an opcode
          state_next = S_IDLE;
          case (rx_byte)
            OP_VOLUME: state_next = S_VOLUME;
            OP_FOLDER: state_next = S_FOLDER;
            OP_DUTY:   state_next = S_DUTY;
            OP_LOG_DUMP: begin
              push       = 1'b1;
              cmd.action = ACT_LOG_DUMP;
            end
            OP_SCHEDULE: begin
              push              = 1'b1;
              cmd.action        = ACT_SCHED_BEGIN;
              rec_next          = '0;
              record_count_next = 8'd0;
              state_next        = S_REC_START;
            end
            OP_STATUS: begin
              push       = 1'b1;
              cmd.action = ACT_STATUS;
            end
            OP_CLEAR_SCHED: begin
              push       = 1'b1;
              cmd.action = ACT_CLEAR_SCHED;
            end
            OP_CLEAR_LOGS: begin
              push       = 1'b1;
              cmd.action = ACT_CLEAR_LOGS;
            end
            OP_SET_TIME: begin
              time_idx_next = 2'd0;
              state_next    = S_TIME;
            end
            OP_TIME_QUERY: begin
              push       = 1'b1;
              cmd.action = ACT_TIME_QUERY;
            end
            default: state_next = S_IDLE;
          endcase
        end
      endcase
    end
  end

  // Hold frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rec_idx      <= 3'd0;
      time_idx     <= 2'd0;
      held_folder  <= 8'd0;
      rec          <= '0;
      record_count <= 8'd0;
    end else begin
      state        <= state_next;
      rec_idx      <= rec_idx_next;
      time_idx     <= time_idx_next;
      held_folder  <= held_folder_next;
      rec          <= rec_next;
      record_count <= record_count_next;
    end
  end

endmodule

>>> design/sfcp_queue.sv
// Short command queue between the front and back parts.
`timescale 1ns / 1ps

module sfcp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sfcp_pkg::sfcp_cmd_t push_cmd,
  input  logic                pop,
  output sfcp_pkg::sfcp_cmd_t head,
  output logic                empty,
  output logic                full
);
  import sfcp_pkg::*;

  sfcp_cmd_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign empty   = (count == '0);
  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

endmodule

>>> design/sfcp_back.sv
// Back part: turns queued commands into result words in an output register.
`timescale 1ns / 1ps

module sfcp_back (
  input  logic                clk,
  input  logic                rst,
  input  sfcp_pkg::sfcp_cmd_t head,
  input  logic                empty,
  output logic                pop,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [3:0]          action,
  output logic [7:0]          value,
  output logic [7:0]          rec_month,
  output logic [7:0]          rec_day_start,
  output logic [7:0]          rec_start,
  output logic [7:0]          rec_day_stop,
  output logic [7:0]          rec_stop,
  output logic [7:0]          rec_folder,
  output logic [7:0]          rec_track,
  output logic [1:0]          clock_field,
  output logic                last
);
  import sfcp_pkg::*;

  logic        load;
  logic        stop_pending;
  logic [15:0] tens_prod;
  logic [3:0]  tens;
  logic [7:0]  ones;
  logic [7:0]  bcd;
  logic [7:0]  head_value;

  // Load the output register when it is empty or being taken
  assign load = !out_valid || !out_stall;
  assign pop  = load && !stop_pending && !empty;

  // Binary to BCD for clock values below 100: tens by reciprocal multiply
  assign tens_prod = {8'd0, head.value} * 16'd205;
  assign tens      = tens_prod[14:11];
  assign ones      = head.value - ({3'd0, tens, 1'b0} + {1'b0, tens, 3'd0});
  assign bcd       = {tens, ones[3:0]};
  assign head_value = (head.action == ACT_CLOCK_WRITE) ? bcd : head.value;

  // Hold or advance the result word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      stop_pending <= 1'b0;
    end else if (load) begin
      if (stop_pending) begin
        out_valid    <= 1'b1;
        stop_pending <= 1'b0;
      end else if (!empty) begin
        out_valid    <= 1'b1;
        stop_pending <= head.with_stop;
      end else begin
        out_valid    <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      if (stop_pending) begin
        action        <= ACT_STOP_REPLY;
        value         <= 8'd0;
        rec_month     <= 8'd0;
        rec_day_start <= 8'd0;
        rec_start     <= 8'd0;
        rec_day_stop  <= 8'd0;
        rec_stop      <= 8'd0;
        rec_folder    <= 8'd0;
        rec_track     <= 8'd0;
        clock_field   <= 2'd0;
        last          <= 1'b1;
      end else begin
        action        <= head.action;
        value         <= head_value;
        rec_month     <= head.rec[0];
        rec_day_start <= head.rec[1];
        rec_start     <= head.rec[2];
        rec_day_stop  <= head.rec[3];
        rec_stop      <= head.rec[4];
        rec_folder    <= head.rec[REC_FOLDER_IDX];
        rec_track     <= head.rec[REC_TRACK_IDX];
        clock_field   <= head.field;
        last          <= !head.with_stop;
      end
    end
  end

endmodule

>>> design/serial_command_frame_parser.sv
// Top level of the serial command frame parser.
`timescale 1ns / 1ps

// Accepts one received byte per clock whenever in_stall is low; in_stall rises
// only while the four-entry command queue between the byte decoder and the
// result stage is full. Each byte gives zero, one or two result words; a
// result word waits in the command queue and is loaded into the output
// register when that is empty or being taken. Bytes that cause two words
// (record append then the stop reply) give both in turn, so the sustained
// rate is one byte per cycle except for those, and only while out_stall is
// low. schedule_limit is written through cfg_wr_en and cfg_wr_data and
// resets to 180; write it only while the block is idle.
module serial_command_frame_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] action,
  output logic [7:0] value,
  output logic [7:0] rec_month,
  output logic [7:0] rec_day_start,
  output logic [7:0] rec_start,
  output logic [7:0] rec_day_stop,
  output logic [7:0] rec_stop,
  output logic [7:0] rec_folder,
  output logic [7:0] rec_track,
  output logic [1:0] clock_field,
  output logic       last
);
  import sfcp_pkg::*;

  logic [7:0] schedule_limit;
  logic       push, pop, q_empty, q_full;
  sfcp_cmd_t  push_cmd, head;

  assign in_stall = q_full;

  // Hold the schedule limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      schedule_limit <= SCHEDULE_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      schedule_limit <= cfg_wr_data;
    end
  end

  sfcp_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (q_full),
    .rx_byte        (rx_byte),
    .schedule_limit (schedule_limit),
    .push           (push),
    .cmd            (push_cmd)
  );

  sfcp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  sfcp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .empty         (q_empty),
    .pop           (pop),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .action        (action),
    .value         (value),
    .rec_month     (rec_month),
    .rec_day_start (rec_day_start),
    .rec_start     (rec_start),
    .rec_day_stop  (rec_day_stop),
    .rec_stop      (rec_stop),
    .rec_folder    (rec_folder),
    .rec_track     (rec_track),
    .clock_field   (clock_field),
    .last          (last)
  );

endmodule
